>>> hw/rtl/contiguous_unit_allocator_assert.svh
// Assertion macros shared by the contiguous unit allocator RTL.
`ifndef CONTIGUOUS_UNIT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_UNIT_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define CUA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CUA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CUA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CUA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/cua_pkg.sv
// Shared types, codes and constants of the contiguous unit allocator.
`default_nettype none

package cua_pkg;

    // Parameter defaults
    localparam int UNITS_DEF      = 32;
    localparam int OWNER_BITS_DEF = 8;

    // Fixed field widths
    localparam int ID_W     = 8;
    localparam int SIZE_W   = 6;
    localparam int STATUS_W = 2;
    localparam int START_W  = 5;
    localparam int COUNT_W  = 6;
    localparam int POLICY_W = 2;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FIT_POLICY = 1'b0;  // register index, paddr[2]

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Fit policies; the spare code behaves as first fit
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   owner_id;
        logic [SIZE_W-1:0] request_size;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start_unit;
        logic [COUNT_W-1:0]  unit_count;
    } t_res;

endpackage

`default_nettype wire

>>> hw/rtl/cua_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry in the cycle after its address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/cua_apb_regs.sv
// APB configuration register file: the fit policy register.
`default_nettype none

module cua_apb_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cua_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [cua_pkg::PDATA_W-1:0]    pwdata,
    output logic      [cua_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready,
    output logic      [cua_pkg::POLICY_W-1:0]   o_fit_policy
);
    import cua_pkg::*;

    logic [POLICY_W-1:0] r_fit_policy;
    logic                w_wr;
    logic                w_hit;

    assign pready = 1'b1;
    assign w_hit  = (paddr[2] == REG_FIT_POLICY);
    assign w_wr   = psel && penable && pwrite && pready;

    // Take a write beat on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy <= POL_FIRST;
        end else if (w_wr && w_hit) begin
            r_fit_policy <= pwdata[POLICY_W-1:0];
        end
    end

    // Read back the register, zero elsewhere
    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = PDATA_W'(r_fit_policy);
        end
    end

    assign o_fit_policy = r_fit_policy;

endmodule

`default_nettype wire

>>> hw/rtl/cua_engine.sv
// Allocation engine: clears the owner map, scans it run by run, writes back the chosen run.
`default_nettype none

`include "contiguous_unit_allocator_assert.svh"

module cua_engine #(
    parameter int UNITS      = cua_pkg::UNITS_DEF,
    parameter int OWNER_BITS = cua_pkg::OWNER_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_req_valid,
    output logic                                 o_req_ready,
    input  wire cua_pkg::t_req                   i_req,
    input  wire logic [cua_pkg::POLICY_W-1:0]    i_fit_policy,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_ready,
    output cua_pkg::t_res                        o_res,
    output logic                                 o_ram_we,
    output logic      [$clog2(UNITS)-1:0]        o_ram_waddr,
    output logic      [OWNER_BITS-1:0]           o_ram_wdata,
    output logic      [$clog2(UNITS)-1:0]        o_ram_raddr,
    input  wire logic [OWNER_BITS-1:0]           i_ram_rdata
);
    import cua_pkg::*;

    localparam int AW = $clog2(UNITS);
    localparam int LW = $clog2(UNITS + 1);
    localparam int IW = $clog2(UNITS + 2);
    localparam int CW = (LW > SIZE_W) ? LW : SIZE_W;

    t_state                r_state, n_state;
    logic                  r_kind, n_kind;
    logic [OWNER_BITS-1:0] r_id, n_id;
    logic [SIZE_W-1:0]     r_size, n_size;
    logic [IW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_run_start, n_run_start;
    logic [OWNER_BITS-1:0] r_run_owner, n_run_owner;
    logic [LW-1:0]         r_run_len, n_run_len;
    logic                  r_found, n_found;
    logic [AW-1:0]         r_best_start, n_best_start;
    logic [LW-1:0]         r_best_len, n_best_len;
    logic [AW-1:0]         r_wr_addr, n_wr_addr;
    logic [LW-1:0]         r_wr_left, n_wr_left;
    t_res                  r_res, n_res;

    logic [OWNER_BITS-1:0] w_req_id;
    logic                  w_have_data;
    logic                  w_last;
    logic                  w_boundary;
    logic                  w_free_hit;
    logic                  w_fits;
    logic                  w_take;
    logic                  w_stop_first;
    logic                  w_multi_pol;

    // Mask the owner to the map width
    assign w_req_id = OWNER_BITS'(i_req.owner_id);

    // Scan decode: data for unit r_idx-1 is on the read port; r_idx == UNITS+1 closes the map
    assign w_have_data  = (r_idx != '0);
    assign w_last       = (r_idx == IW'(UNITS + 1));
    assign w_boundary   = (r_idx > IW'(1)) && (w_last || (i_ram_rdata != r_run_owner));
    assign w_free_hit   = (r_kind == KIND_FREE) && (r_run_owner == r_id);
    assign w_fits       = (r_kind == KIND_ALLOC) && (r_run_owner == '0)
                          && (CW'(r_run_len) >= CW'(r_size));
    assign w_multi_pol  = (i_fit_policy == POL_BEST) || (i_fit_policy == POL_WORST);
    assign w_take       = w_fits && (!r_found
                          || ((i_fit_policy == POL_BEST) && (r_run_len < r_best_len))
                          || ((i_fit_policy == POL_WORST) && (r_run_len > r_best_len)));
    assign w_stop_first = w_fits && !r_found && !w_multi_pol;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_wr_left == LW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    if (w_req_id == '0) begin
                        n_state = S_EMIT;
                    end else if ((i_req.kind == KIND_ALLOC) && (i_req.request_size == '0)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                priority if (w_boundary && (w_free_hit || w_stop_first)) begin
                    n_state = S_WRITE;
                end else if (w_last) begin
                    n_state = (w_take || r_found) ? S_WRITE : S_EMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_WRITE: begin
                if (r_wr_left == LW'(1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_res_valid = (r_state == S_EMIT);
        o_res       = r_res;
        o_ram_raddr = r_idx[AW-1:0];
        o_ram_we    = (r_state == S_WRITE) || (r_state == S_CLEAR);
        o_ram_waddr = r_wr_addr;
        o_ram_wdata = ((r_state == S_CLEAR) || (r_kind == KIND_FREE)) ? '0 : r_id;
    end

    // Datapath: latch the request, track runs, pick the hole, step the write pass
    always_comb begin
        n_kind       = r_kind;
        n_id         = r_id;
        n_size       = r_size;
        n_idx        = r_idx;
        n_run_start  = r_run_start;
        n_run_owner  = r_run_owner;
        n_run_len    = r_run_len;
        n_found      = r_found;
        n_best_start = r_best_start;
        n_best_len   = r_best_len;
        n_wr_addr    = r_wr_addr;
        n_wr_left    = r_wr_left;
        n_res        = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind  = i_req.kind;
                    n_id    = w_req_id;
                    n_size  = i_req.request_size;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_res   = '{status: ST_NOT_FOUND, start_unit: '0, unit_count: '0};
                    if ((w_req_id != '0) && (i_req.kind == KIND_ALLOC)) begin
                        n_res.status = ST_NO_FIT;
                    end
                end
            end
            S_SCAN: begin
                n_idx = IW'(r_idx + 1'b1);
                // Extend the current run or open a new one
                if (w_have_data && !w_last) begin
                    if ((r_idx == IW'(1)) || (i_ram_rdata != r_run_owner)) begin
                        n_run_start = AW'(r_idx - 1'b1);
                        n_run_owner = i_ram_rdata;
                        n_run_len   = LW'(1);
                    end else begin
                        n_run_len = LW'(r_run_len + 1'b1);
                    end
                end
                // Judge the run that just closed
                if (w_boundary) begin
                    if (w_free_hit) begin
                        n_wr_addr = r_run_start;
                        n_wr_left = r_run_len;
                        n_res     = '{status: ST_DONE,
                                      start_unit: START_W'(r_run_start),
                                      unit_count: COUNT_W'(r_run_len)};
                    end else if (w_take) begin
                        n_found      = 1'b1;
                        n_best_start = r_run_start;
                        n_best_len   = r_run_len;
                        n_wr_addr    = r_run_start;
                        n_wr_left    = LW'(r_size);
                        n_res        = '{status: ST_DONE,
                                         start_unit: START_W'(r_run_start),
                                         unit_count: r_size};
                    end
                end
            end
            S_WRITE, S_CLEAR: begin
                n_wr_addr = AW'(r_wr_addr + 1'b1);
                n_wr_left = LW'(r_wr_left - 1'b1);
            end
            S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers reset; the clearing pass starts at unit 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_wr_addr <= '0;
            r_wr_left <= LW'(UNITS);
            r_found   <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_wr_addr <= n_wr_addr;
            r_wr_left <= n_wr_left;
            r_found   <= n_found;
            r_idx     <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_id         <= n_id;
        r_size       <= n_size;
        r_run_start  <= n_run_start;
        r_run_owner  <= n_run_owner;
        r_run_len    <= n_run_len;
        r_best_start <= n_best_start;
        r_best_len   <= n_best_len;
        r_res        <= n_res;
    end

    `CUA_ASSERT_IMP(a_we_only_in_write, i_clk, i_rst_n, o_ram_we, (r_state == S_WRITE) || (r_state == S_CLEAR), "owner map written outside a write pass")
    `CUA_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, i_req_valid && o_req_ready, r_state != S_IDLE, "accepted request did not start")
    `CUA_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n, r_state == S_SCAN, r_idx <= IW'(UNITS + 1), "scan index ran past the map")
    `CUA_ASSERT_IMP(a_write_count_live, i_clk, i_rst_n, (r_state == S_WRITE) || (r_state == S_CLEAR), r_wr_left != '0, "write pass with no units left")

endmodule

`default_nettype wire

>>> hw/rtl/contiguous_unit_allocator.sv
// Top level of the contiguous unit allocator: stream ports, config port, owner map, result register.
// Flow: an allocate or free request is accepted, the owner map is scanned (one map read per
// cycle through the single RAM read port), the chosen run is written back unit by unit, and
// the result goes into the result register. A zero owner or zero-size allocate skips scan and write.
// One request at a time. Reset: synchronous, active low; a clearing pass then zeroes the
// owner map, and s_axis_tready stays low until it ends. The fit policy resets to first fit.
`default_nettype none

module contiguous_unit_allocator #(
    parameter int UNITS      = cua_pkg::UNITS_DEF,
    parameter int OWNER_BITS = cua_pkg::OWNER_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [15:0]                   s_axis_tdata,  // owner_id[7:0], request_size[13:8]
    input  wire logic                          s_axis_tuser,  // kind
    // Result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [15:0]                   m_axis_tdata,  // status[1:0], start_unit[6:2],
                                                              // unit_count[12:7]
    // Configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cua_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [cua_pkg::PDATA_W-1:0]   pwdata,
    output logic      [cua_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import cua_pkg::*;

    localparam int AW = $clog2(UNITS);

    t_req                  w_req;
    t_res                  w_res;
    logic                  w_res_valid;
    logic                  w_res_ready;
    logic [POLICY_W-1:0]   w_fit_policy;
    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_waddr;
    logic [OWNER_BITS-1:0] w_ram_wdata;
    logic [AW-1:0]         w_ram_raddr;
    logic [OWNER_BITS-1:0] w_ram_rdata;

    logic                  r_m_valid;
    t_res                  r_m_res;

    // Unpack the request beat
    assign w_req.kind         = s_axis_tuser;
    assign w_req.owner_id     = s_axis_tdata[ID_W-1:0];
    assign w_req.request_size = s_axis_tdata[ID_W+SIZE_W-1:ID_W];

    cua_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fit_policy (w_fit_policy)
    );

    cua_ram #(
        .WIDTH (OWNER_BITS),
        .DEPTH (UNITS)
    ) u_owner_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    cua_engine #(
        .UNITS      (UNITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req        (w_req),
        .i_fit_policy (w_fit_policy),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata)
    );

    // Output register: load when empty or when the current beat leaves
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    // Pack the result beat
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_m_res.unit_count, r_m_res.start_unit, r_m_res.status};

endmodule

`default_nettype wire
